@@ sv/flow_latency_tracker_core_assert.svh @@
// ----------------------------------------------------------------------------
// flow latency tracker assertion macros
// clocked assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FLOW_LATENCY_TRACKER_CORE_ASSERT_SVH
`define FLOW_LATENCY_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FLT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FLT_ASSERT(lbl, prop, msg)
`define FLT_NEVER(lbl, cond, msg)
`endif

`endif

@@ sv/flt_pkg.sv @@
// ----------------------------------------------------------------------------
// flt_pkg
// shared constants, result codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package flt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KEY_W   = 48;
    localparam int TIME_W  = 64;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int LEN_W   = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_RECORDED = 3'd1,
        ST_HELD = 3'd2,
        ST_FULL = 3'd3,
        ST_MATCHED = 3'd4,
        ST_NOMATCH = 3'd5
    } status_t;

    typedef struct packed {
        logic            valid;
        logic [KEY_W-1:0] key;
    } flt_entry_t;

    typedef struct packed {
        logic    load;
        logic    clear_step;
        logic    scan_step;
        logic    record;
        logic    unlink;
        logic    emit;
        status_t code;
    } flt_cmd_t;

    typedef struct packed {
        logic in_ok;
        logic addr_last;
        logic is_egress;
        logic match_found;
        logic free_found;
    } flt_stat_t;

endpackage

@@ sv/flow_latency_tracker_core.sv @@
// ----------------------------------------------------------------------------
// flow_latency_tracker_core: ignored frames give done in the cycle after start, busy stays low
// other frames give done after the scan, drain and decide states, plus a wait state on an egress match
// busy is high outside the idle state; the key ram scan reads one entry per cycle
// reset clears the flow table in a pass over every entry with busy high
// ----------------------------------------------------------------------------
module flow_latency_tracker_core
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [15:0]       ether_type,
    input  logic [3:0]        ip_header_words,
    input  logic [7:0]        ip_protocol,
    input  logic [ADDR_W-1:0] ip_address,
    input  logic [PORT_W-1:0] port,
    input  logic [LEN_W-1:0]  captured_length,
    input  logic [TIME_W-1:0] time_ns,
    output logic              done,
    output logic [2:0]        status,
    output logic              is_tcp,
    output logic [TIME_W-1:0] delay_ns
);

    flt_cmd_t  cmd;
    flt_stat_t stat;

    flt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    flt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .ether_type      (ether_type),
        .ip_header_words (ip_header_words),
        .ip_protocol     (ip_protocol),
        .ip_address      (ip_address),
        .port            (port),
        .captured_length (captured_length),
        .time_ns         (time_ns),
        .done            (done),
        .status          (status),
        .is_tcp          (is_tcp),
        .delay_ns        (delay_ns)
    );

endmodule

@@ sv/flt_ram.sv @@
// ----------------------------------------------------------------------------
// flt_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/flt_dp.sv @@
// ----------------------------------------------------------------------------
// flt_dp
// frame checks, flow table storage, sequential key scan and result registers
// ----------------------------------------------------------------------------
module flt_dp
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  flt_cmd_t          cmd,
    output flt_stat_t         stat,
    input  logic              req_type,
    input  logic [15:0]       ether_type,
    input  logic [3:0]        ip_header_words,
    input  logic [7:0]        ip_protocol,
    input  logic [ADDR_W-1:0] ip_address,
    input  logic [PORT_W-1:0] port,
    input  logic [LEN_W-1:0]  captured_length,
    input  logic [TIME_W-1:0] time_ns,
    output logic              done,
    output logic [2:0]        status,
    output logic              is_tcp,
    output logic [TIME_W-1:0] delay_ns
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = $bits(flt_entry_t);

    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              cmp_valid_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;
    logic              tcp_reg;
    logic              done_reg;
    status_t           status_reg;
    logic              is_tcp_reg;
    logic [TIME_W-1:0] delay_reg;

    logic              in_tcp;
    logic              in_udp;
    logic [15:0]       need_bytes;
    logic              hit;
    logic              empty;

    logic [IDX_W-1:0]  k_addr;
    logic              k_we;
    flt_entry_t        k_wdata;
    logic [ENTRY_W-1:0] k_rdata_raw;
    flt_entry_t        k_rdata;
    logic [IDX_W-1:0]  t_addr;
    logic [TIME_W-1:0] t_rdata;

    // frame checks
    assign in_tcp = (ip_protocol == PROTO_TCP);
    assign in_udp = (ip_protocol == PROTO_UDP);
    assign need_bytes = ETH_HDR_BYTES + {10'b0, ip_header_words, 2'b00}
                      + (in_tcp ? TCP_HDR_BYTES : UDP_HDR_BYTES);

    assign stat.in_ok = (ether_type == ETHERTYPE_IPV4) && (ip_header_words >= MIN_IHL)
                      && (in_tcp || in_udp) && (need_bytes <= captured_length);
    assign stat.addr_last   = (addr_reg == LAST_IDX);
    assign stat.is_egress   = req_reg;
    assign stat.match_found = match_found_reg;
    assign stat.free_found  = free_found_reg;

    // table storage
    always_comb
    begin
        k_addr  = addr_reg;
        k_we    = 1'b0;
        k_wdata = '0;
        if (cmd.clear_step)
        begin
            k_we = 1'b1;
        end
        else if (cmd.record)
        begin
            k_addr        = free_idx_reg;
            k_we          = 1'b1;
            k_wdata.valid = 1'b1;
            k_wdata.key   = key_reg;
        end
        else if (cmd.unlink)
        begin
            k_addr = match_idx_reg;
            k_we   = 1'b1;
        end
    end

    assign t_addr = cmd.record ? free_idx_reg : match_idx_reg;

    flt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .addr  (k_addr),
        .wdata (k_wdata),
        .rdata (k_rdata_raw)
    );

    assign k_rdata = k_rdata_raw;

    flt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_time_ram (
        .clk   (clk),
        .we    (cmd.record),
        .addr  (t_addr),
        .wdata (time_reg),
        .rdata (t_rdata)
    );

    // scan compare, first hit and first free slot
    assign hit   = cmp_valid_reg && k_rdata.valid && (k_rdata.key == key_reg);
    assign empty = cmp_valid_reg && !k_rdata.valid;

    always_comb
    begin
        addr_next        = addr_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        if (cmd.load)
        begin
            addr_next        = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else
        begin
            if (cmd.clear_step || cmd.scan_step)
            begin
                addr_next = addr_reg + 1'b1;
            end
            if (hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
            end
            if (empty && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg        <= '0;
            cmp_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            addr_reg        <= addr_next;
            cmp_valid_reg   <= cmd.scan_step;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            done_reg        <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= addr_reg;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        if (cmd.load)
        begin
            req_reg  <= req_type;
            key_reg  <= {ip_address, port};
            time_reg <= time_ns;
            tcp_reg  <= in_tcp;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            is_tcp_reg <= (cmd.code == ST_IGNORED) ? 1'b0 : tcp_reg;
            delay_reg  <= (cmd.code == ST_MATCHED) ? (time_reg - t_rdata) : '0;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign is_tcp   = is_tcp_reg;
    assign delay_ns = delay_reg;

endmodule

@@ sv/flt_ctrl.sv @@
// ----------------------------------------------------------------------------
// flt_ctrl
// sequencer for table clearing, key scan, table update and result strobe
// ----------------------------------------------------------------------------
`include "flow_latency_tracker_core_assert.svh"

module flt_ctrl
    import flt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output flt_cmd_t  cmd,
    input  flt_stat_t stat
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_DECIDE = 6'b010000,
        S_WAIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_IGNORED;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.in_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_IGNORED;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (!stat.is_egress)
                begin
                    cmd.emit = 1'b1;
                    if (stat.match_found)
                    begin
                        cmd.code = ST_HELD;
                    end
                    else if (stat.free_found)
                    begin
                        cmd.record = 1'b1;
                        cmd.code   = ST_RECORDED;
                    end
                    else
                    begin
                        cmd.code = ST_FULL;
                    end
                end
                else if (stat.match_found)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_NOMATCH;
                end
            end
            S_WAIT:
            begin
                cmd.emit   = 1'b1;
                cmd.code   = ST_MATCHED;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `FLT_ASSERT(a_record_free, cmd.record |-> (stat.free_found && !stat.match_found && !stat.is_egress), "record without a free entry")
    `FLT_ASSERT(a_unlink_match, cmd.unlink |-> (stat.match_found && stat.is_egress), "unlink without a match")
    `FLT_ASSERT(a_unlink_emit, cmd.unlink |=> (cmd.emit && cmd.code == ST_MATCHED), "match result not sent after unlink")
    `FLT_ASSERT(a_scan_end, (state_reg == S_SCAN && stat.addr_last) |=> (state_reg == S_DRAIN), "scan did not end at last entry")
    `FLT_NEVER(a_emit_busy, cmd.emit && cmd.load, "load and result in the same cycle")

endmodule
